// ===== rtl/core/rbst_pkg.sv =====
// Shared constants and types for the ray/box slab test core.
package rbst_pkg;

    // Coordinate format: signed Q16.16
    localparam int CW = 32;
    localparam int FB = 16;

    // Divider: quotient bits retired per stage and number of stages
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 8;
    // Saturation register, step stages, output register
    localparam int DIV_LAT    = DIV_STAGES + 2;

    // APB address width: six 32-bit registers at 4*i
    localparam int AW = 5;

    typedef logic [CW-1:0] word_t;
    typedef logic [CW:0]   mag_t;

    localparam word_t SAT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam word_t SAT_MIN = {1'b1, {(CW-1){1'b0}}};

    // Register indexes
    typedef enum logic [2:0] {
        REG_LOW_X  = 3'd0,
        REG_LOW_Y  = 3'd1,
        REG_LOW_Z  = 3'd2,
        REG_HIGH_X = 3'd3,
        REG_HIGH_Y = 3'd4,
        REG_HIGH_Z = 3'd5
    } reg_idx_t;

    // Partial state of the restoring divider
    typedef struct packed {
        word_t rem;
        word_t dvd;
        word_t quo;
    } div_st_t;

endpackage

// ===== rtl/core/rbst_div.sv =====
// Pipelined saturating fixed-point divider: (num << FB) / den, magnitudes in, signed out.
module rbst_div (
    input  logic               clk,
    input  logic               en,
    input  rbst_pkg::mag_t     num_mag,
    input  rbst_pkg::word_t    den_mag,
    input  logic               neg,
    output rbst_pkg::word_t    quot
);

    // Retire DIV_STEPS quotient bits
    function automatic rbst_pkg::div_st_t div_steps(rbst_pkg::div_st_t s,
                                                    rbst_pkg::word_t den);
        logic [rbst_pkg::CW:0] t;
        rbst_pkg::div_st_t     o;
        o = s;
        for (int k = 0; k < rbst_pkg::DIV_STEPS; k++)
        begin
            t     = {o.rem, o.dvd[rbst_pkg::CW-1]};
            o.dvd = {o.dvd[rbst_pkg::CW-2:0], 1'b0};
            if (t >= {1'b0, den})
            begin
                o.rem = rbst_pkg::CW'(t - {1'b0, den});
                o.quo = {o.quo[rbst_pkg::CW-2:0], 1'b1};
            end
            else
            begin
                o.rem = t[rbst_pkg::CW-1:0];
                o.quo = {o.quo[rbst_pkg::CW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    localparam int PADW = rbst_pkg::CW - 1 - rbst_pkg::FB;

    rbst_pkg::div_st_t st_reg  [rbst_pkg::DIV_STAGES+1];
    rbst_pkg::div_st_t st_next [rbst_pkg::DIV_STAGES];
    rbst_pkg::word_t   den_reg [rbst_pkg::DIV_STAGES+1];
    logic              neg_reg [rbst_pkg::DIV_STAGES+1];
    logic              sat_reg [rbst_pkg::DIV_STAGES+1];
    rbst_pkg::word_t   quot_reg;

    // Entry stage: overflow check and initial remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0].rem <= rbst_pkg::CW'(num_mag[rbst_pkg::CW:rbst_pkg::FB]);
            st_reg[0].dvd <= {num_mag[rbst_pkg::CW-rbst_pkg::FB-1:0], {rbst_pkg::FB{1'b0}}};
            st_reg[0].quo <= '0;
            den_reg[0]    <= den_mag;
            neg_reg[0]    <= neg;
            // quotient reaches 2^(CW-1) exactly when num >= den << (CW-1-FB)
            sat_reg[0]    <= {{PADW{1'b0}}, num_mag} >= {1'b0, den_mag, {PADW{1'b0}}};
        end
    end

    // Step stages
    for (genvar s = 0; s < rbst_pkg::DIV_STAGES; s++)
    begin : g_stage
        always_comb
        begin
            st_next[s] = div_steps(st_reg[s], den_reg[s]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[s+1]  <= st_next[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                sat_reg[s+1] <= sat_reg[s];
            end
        end
    end

    // Sign and saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sat_reg[rbst_pkg::DIV_STAGES])
                quot_reg <= neg_reg[rbst_pkg::DIV_STAGES] ? rbst_pkg::SAT_MIN
                                                           : rbst_pkg::SAT_MAX;
            else if (neg_reg[rbst_pkg::DIV_STAGES])
                quot_reg <= -st_reg[rbst_pkg::DIV_STAGES].quo;
            else
                quot_reg <= st_reg[rbst_pkg::DIV_STAGES].quo;
        end
    end

    assign quot = quot_reg;

endmodule

// ===== rtl/core/ray_box_slab_test_core.sv =====
// Top level of the ray/box slab intersection test.
//
// Usage:
//   Rays enter on the input channel (in_valid/in_ready) as origin and direction,
//   signed Q16.16 per axis. One hit bit per ray leaves on the output channel
//   (out_valid/out_ready), in order.
//   The box corners sit in six APB registers (low x,y,z at 0x00..0x08, high
//   x,y,z at 0x0C..0x14); write them only while no ray is in flight.
//   Pipeline: thirteen registers in line (difference stage, ten divider stages,
//   min/max stage, output register), the first loaded at the input accept edge.
//   Throughput: one ray per cycle while the output is not stalled; the six
//   dividers are fully pipelined, four quotient bits per stage.
//   Stall: when the output register holds an item that is not taken, the
//   whole pipeline freezes and in_ready drops; nothing is lost or repeated.
//   Reset: rst_n clears all valid bits and the box registers to zero.
//   A zero direction component leaves that axis unbounded if the origin is
//   inside its slab, otherwise forces a miss. No t >= 0 test is made.
module ray_box_slab_test_core (
    input  logic                   clk,
    input  logic                   rst_n,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [rbst_pkg::AW-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Ray input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [31:0]     ray_origin_x,
    input  logic signed [31:0]     ray_origin_y,
    input  logic signed [31:0]     ray_origin_z,
    input  logic signed [31:0]     ray_dir_x,
    input  logic signed [31:0]     ray_dir_y,
    input  logic signed [31:0]     ray_dir_z,
    // Result output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit
);

    localparam int LAT = rbst_pkg::DIV_LAT;

    rbst_pkg::word_t box_lo_reg [3];
    rbst_pkg::word_t box_hi_reg [3];

    rbst_pkg::reg_idx_t widx;
    logic               en;

    // Stage A
    logic            va_reg;
    rbst_pkg::mag_t  nlo_reg [3];
    rbst_pkg::mag_t  nhi_reg [3];
    rbst_pkg::word_t den_reg [3];
    logic            neglo_reg [3];
    logic            neghi_reg [3];
    logic [2:0]      dz_reg;
    logic            miss_reg;

    // Side pipeline aligned with the dividers
    logic            vs_reg    [LAT];
    logic [2:0]      dzs_reg   [LAT];
    logic            misss_reg [LAT];

    rbst_pkg::word_t tlo [3];
    rbst_pkg::word_t thi [3];

    // Stage C
    logic            vc_reg;
    logic            missc_reg;
    rbst_pkg::word_t enter_reg;
    rbst_pkg::word_t leave_reg;

    // Output register
    logic            out_valid_reg;
    logic            hit_reg;

    rbst_pkg::word_t org [3];
    rbst_pkg::word_t dir [3];

    assign org[0] = ray_origin_x;
    assign org[1] = ray_origin_y;
    assign org[2] = ray_origin_z;
    assign dir[0] = ray_dir_x;
    assign dir[1] = ray_dir_y;
    assign dir[2] = ray_dir_z;

    // Global advance: freeze everything while the output item waits
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;

    // Register file
    assign widx = rbst_pkg::reg_idx_t'(paddr[rbst_pkg::AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            unique case (widx)
                rbst_pkg::REG_LOW_X:  box_lo_reg[0] <= pwdata;
                rbst_pkg::REG_LOW_Y:  box_lo_reg[1] <= pwdata;
                rbst_pkg::REG_LOW_Z:  box_lo_reg[2] <= pwdata;
                rbst_pkg::REG_HIGH_X: box_hi_reg[0] <= pwdata;
                rbst_pkg::REG_HIGH_Y: box_hi_reg[1] <= pwdata;
                rbst_pkg::REG_HIGH_Z: box_hi_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            rbst_pkg::REG_LOW_X:  prdata = box_lo_reg[0];
            rbst_pkg::REG_LOW_Y:  prdata = box_lo_reg[1];
            rbst_pkg::REG_LOW_Z:  prdata = box_lo_reg[2];
            rbst_pkg::REG_HIGH_X: prdata = box_hi_reg[0];
            rbst_pkg::REG_HIGH_Y: prdata = box_hi_reg[1];
            rbst_pkg::REG_HIGH_Z: prdata = box_hi_reg[2];
            default:              prdata = '0;
        endcase
    end

    // Stage A: plane distances, magnitudes, signs, zero-direction check
    logic [rbst_pkg::CW:0] dlo [3];
    logic [rbst_pkg::CW:0] dhi [3];
    logic [2:0]            out_slab;
    logic [2:0]            dz;

    for (genvar a = 0; a < 3; a++)
    begin : g_diff
        assign dlo[a] = {box_lo_reg[a][rbst_pkg::CW-1], box_lo_reg[a]}
                      - {org[a][rbst_pkg::CW-1], org[a]};
        assign dhi[a] = {box_hi_reg[a][rbst_pkg::CW-1], box_hi_reg[a]}
                      - {org[a][rbst_pkg::CW-1], org[a]};
        assign dz[a]  = (dir[a] == '0);
        // origin below low plane or above high plane
        assign out_slab[a] = (!dlo[a][rbst_pkg::CW] && (dlo[a] != '0)) || dhi[a][rbst_pkg::CW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                nlo_reg[a]   <= dlo[a][rbst_pkg::CW] ? -dlo[a] : dlo[a];
                nhi_reg[a]   <= dhi[a][rbst_pkg::CW] ? -dhi[a] : dhi[a];
                den_reg[a]   <= dir[a][rbst_pkg::CW-1] ? -dir[a] : dir[a];
                neglo_reg[a] <= dlo[a][rbst_pkg::CW] ^ dir[a][rbst_pkg::CW-1];
                neghi_reg[a] <= dhi[a][rbst_pkg::CW] ^ dir[a][rbst_pkg::CW-1];
            end
            dz_reg   <= dz;
            miss_reg <= |(dz & out_slab);
        end
    end

    // Six dividers
    for (genvar a = 0; a < 3; a++)
    begin : g_div
        rbst_div u_div_lo (
            .clk     (clk),
            .en      (en),
            .num_mag (nlo_reg[a]),
            .den_mag (den_reg[a]),
            .neg     (neglo_reg[a]),
            .quot    (tlo[a])
        );
        rbst_div u_div_hi (
            .clk     (clk),
            .en      (en),
            .num_mag (nhi_reg[a]),
            .den_mag (den_reg[a]),
            .neg     (neghi_reg[a]),
            .quot    (thi[a])
        );
    end

    // Side pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vs_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vs_reg[0] <= va_reg;
            for (int k = 1; k < LAT; k++)
                vs_reg[k] <= vs_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dzs_reg[0]   <= dz_reg;
            misss_reg[0] <= miss_reg;
            for (int k = 1; k < LAT; k++)
            begin
                dzs_reg[k]   <= dzs_reg[k-1];
                misss_reg[k] <= misss_reg[k-1];
            end
        end
    end

    // Stage C: per-axis entry/exit and overall max entry / min exit
    rbst_pkg::word_t tn [3];
    rbst_pkg::word_t tx [3];
    rbst_pkg::word_t enter_next;
    rbst_pkg::word_t leave_next;

    always_comb
    begin
        enter_next = rbst_pkg::SAT_MIN;
        leave_next = rbst_pkg::SAT_MAX;
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(tlo[a]) < $signed(thi[a]))
            begin
                tn[a] = tlo[a];
                tx[a] = thi[a];
            end
            else
            begin
                tn[a] = thi[a];
                tx[a] = tlo[a];
            end
            if (!dzs_reg[LAT-1][a])
            begin
                if ($signed(tn[a]) > $signed(enter_next))
                    enter_next = tn[a];
                if ($signed(tx[a]) < $signed(leave_next))
                    leave_next = tx[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg        <= vs_reg[LAT-1];
            out_valid_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            enter_reg <= enter_next;
            leave_reg <= leave_next;
            missc_reg <= misss_reg[LAT-1];
            hit_reg   <= !missc_reg && ($signed(leave_reg) >= $signed(enter_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

endmodule

// ===== tb/tb.sv =====
// Testbench for the ray/box slab intersection core: predicts hit per ray and checks in order.
`timescale 1ns / 100ps

class hit_scoreboard;
    bit     exp_hits[$];
    int     errors;
    longint lo[3];
    longint hi[3];

    function void set_reg(rbst_pkg::reg_idx_t idx, logic [31:0] v);
        if (idx <= rbst_pkg::REG_LOW_Z)
            lo[int'(idx)] = longint'($signed(v));
        else
            hi[int'(idx) - 3] = longint'($signed(v));
    endfunction

    // (num << 16) / den, truncated toward zero, saturated to 32 bits
    function longint slab_quot(longint num, longint den);
        longint  q;
        bit      neg;
        longint  un;
        longint  ud;
        longint  m;
        longint  r;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        m = un / ud;
        r = un % ud;
        for (int i = 0; i < rbst_pkg::FB && m < 64'sh80000000; i++)
        begin
            r = r << 1;
            m = m << 1;
            if (r >= ud)
            begin
                r = r - ud;
                m = m | 1;
            end
        end
        if (neg)
        begin
            if (m > 64'sh80000000)
                m = 64'sh80000000;
            q = -m;
        end
        else
        begin
            if (m > 64'sh7fffffff)
                m = 64'sh7fffffff;
            q = m;
        end
        return q;
    endfunction

    function void note_ray(logic [31:0] org[3], logic [31:0] dir[3]);
        longint enter_t;
        longint leave_t;
        longint o;
        longint d;
        longint t1;
        longint t2;
        bit     miss;
        enter_t = -64'sh80000000;
        leave_t = 64'sh7fffffff;
        miss = 0;
        for (int a = 0; a < 3; a++)
        begin
            o = longint'($signed(org[a]));
            d = longint'($signed(dir[a]));
            if (d == 0)
            begin
                if (o < lo[a] || o > hi[a])
                    miss = 1;
            end
            else
            begin
                t1 = slab_quot(lo[a] - o, d);
                t2 = slab_quot(hi[a] - o, d);
                if ((t1 < t2 ? t1 : t2) > enter_t)
                    enter_t = t1 < t2 ? t1 : t2;
                if ((t1 < t2 ? t2 : t1) < leave_t)
                    leave_t = t1 < t2 ? t2 : t1;
            end
        end
        exp_hits.push_back(!miss && leave_t >= enter_t);
    endfunction

    function void check_hit(bit got);
        bit want;
        if (exp_hits.size() == 0)
        begin
            $display("%0t: unexpected result hit=%0b", $time, got);
            errors++;
            return;
        end
        want = exp_hits.pop_front();
        if (want !== got)
        begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [rbst_pkg::AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] ray_origin_x;
    logic [31:0] ray_origin_y;
    logic [31:0] ray_origin_z;
    logic [31:0] ray_dir_x;
    logic [31:0] ray_dir_y;
    logic [31:0] ray_dir_z;
    logic        out_valid;
    logic        out_ready;
    logic        hit;

    hit_scoreboard sb;
    longint        cycles;
    int            hold_off;
    bit            stall_on;

    ray_box_slab_test_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
        .ray_origin_z(ray_origin_z), .ray_dir_x(ray_dir_x),
        .ray_dir_y(ray_dir_y), .ray_dir_z(ray_dir_z),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 200000)
        begin
            $display("ray_box_slab_test_core regression: fail");
            $finish;
        end
    end

    // Note accepted rays, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_ray('{ray_origin_x, ray_origin_y, ray_origin_z},
                        '{ray_dir_x, ray_dir_y, ray_dir_z});
        if (rst_n && out_valid && out_ready)
            sb.check_hit(hit);
    end

    // Receiver: random stalls, quiet stretches, one long hold-off
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else if (!stall_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic reg_write(rbst_pkg::reg_idx_t idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= rbst_pkg::AW'(int'(idx) * 4);
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Drive one ray; valid stays up across back-to-back items
    task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        in_valid <= 1'b1;
        ray_origin_x <= ox;
        ray_origin_y <= oy;
        ray_origin_z <= oz;
        ray_dir_x <= dx;
        ray_dir_y <= dy;
        ray_dir_z <= dz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        idle_gap(1);
        while (sb.exp_hits.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        logic [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h00140000) - 32'h000a0000;
            2: v = 32'h0;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h80000000;
                    1: v = 32'h7fffffff;
                    2: v = 32'h00000001;
                    default: v = 32'hffffffff;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic int pick_mode();
        int r;
        r = $urandom_range(0, 9);
        return r < 2 ? 0 : (r < 7 ? 1 : (r < 9 ? 2 : 3));
    endfunction

    task automatic box_set(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        reg_write(rbst_pkg::REG_LOW_X, lx);
        reg_write(rbst_pkg::REG_LOW_Y, ly);
        reg_write(rbst_pkg::REG_LOW_Z, lz);
        reg_write(rbst_pkg::REG_HIGH_X, hx);
        reg_write(rbst_pkg::REG_HIGH_Y, hy);
        reg_write(rbst_pkg::REG_HIGH_Z, hz);
    endtask

    task automatic random_rays(int n);
        int burst;
        int sent;
        logic [31:0] o[3];
        logic [31:0] d[3];
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < n; k++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    o[a] = rand_coord(pick_mode());
                    d[a] = rand_coord(pick_mode());
                end
                send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        hold_off = 0;
        stall_on = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        ray_origin_x = '0;
        ray_origin_y = '0;
        ray_origin_z = '0;
        ray_dir_x = '0;
        ray_dir_y = '0;
        ray_dir_z = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset box is a point at the origin
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'h00010000, 0, 0, 0, 0, 0);
        drain();

        // Unit-ish box, directed cases
        box_set(32'hffff0000, 32'hffff0000, 32'hffff0000,
                32'h00010000, 32'h00010000, 32'h00010000);
        send_ray(32'hfffb0000, 0, 0, 32'h00010000, 0, 0);
        send_ray(32'hfffb0000, 32'h00050000, 0, 32'h00010000, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'h00020000, 0, 0, 0, 0, 0);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h00000001, 32'h00000001, 32'h00000001);
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000);
        send_ray(32'h00010000, 32'h00010000, 32'h00010000,
                 32'h7fffffff, 32'hffffffff, 32'h80000000);
        send_ray(32'hfffb0000, 32'hfffb0000, 32'hfffb0000,
                 32'h00010000, 32'h00010000, 32'h00010000);
        send_ray(32'h00050000, 32'hfffb0000, 0, 32'hffff0000, 32'h00010000, 0);
        send_ray(32'h00000000, 32'h00030000, 0, 32'h00010000, 32'h00010000, 0);
        drain();

        // Extreme box corners
        box_set(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_ray(32'h7fffffff, 32'h80000000, 0, 32'h00000001, 32'hffffffff, 0);
        send_ray(0, 0, 0, 32'h00000001, 32'h00000001, 32'h00000001);
        drain();

        // Inverted box
        box_set(32'h00010000, 32'h00010000, 32'h00010000,
                32'hffff0000, 32'hffff0000, 32'hffff0000);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'hfffb0000, 0, 0, 32'h00010000, 32'h00010000, 32'h00010000);
        drain();

        // Random phases with varied boxes and receiver behavior
        for (int ph = 0; ph < 4; ph++)
        begin
            box_set(rand_coord(ph == 3 ? 0 : 1) & 32'hfffbffff,
                    rand_coord(1) & 32'hfffbffff, rand_coord(1) & 32'hfffbffff,
                    rand_coord(ph == 3 ? 0 : 1) | 32'h00040000,
                    rand_coord(1) | 32'h00040000, rand_coord(1) | 32'h00040000);
            stall_on = (ph != 0);
            if (ph == 1)
                hold_off = 80;
            random_rays(100);
            drain();
        end

        if (sb.errors == 0 && sb.exp_hits.size() == 0)
            $display("ray_box_slab_test_core regression: pass");
        else
            $display("ray_box_slab_test_core regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/rbst_pkg.sv
rtl/core/rbst_div.sv
rtl/core/ray_box_slab_test_core.sv
tb/tb.sv
